// ===== rtl/lpe_pkg.sv =====
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types and constants of the light pattern engine: channel count,
// duty ranges, command and pattern codes and the per-channel state word.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int CHANNELS   = 16;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DUTY_LIMIT = 4096;
  // stored duty saturates to [-2*DUTY_LIMIT, 2*DUTY_LIMIT-1]
  localparam int DUTY_W     = $clog2(DUTY_LIMIT) + 2;
  // ramp sum must also hold a 12 bit step and the 12 bit output bound
  localparam int SUM_W      = ((DUTY_W > 13) ? DUTY_W : 13) + 1;

  localparam int RESET_PERIOD       = 1000;
  localparam int RESET_STEP         = 1;
  localparam int BREATHE_START_DUTY = 255;
  localparam int DUTY_OUT_MAX       = 4095;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET_ALL = 2'd1,
    OP_SET_ONE = 2'd2,
    OP_READ    = 2'd3
  } op_e_t;

  localparam logic [2:0] PAT_INIT    = 3'd0;
  localparam logic [2:0] PAT_OFF     = 3'd1;
  localparam logic [2:0] PAT_ON      = 3'd2;
  localparam logic [2:0] PAT_PULSE   = 3'd3;
  localparam logic [2:0] PAT_BREATHE = 3'd4;
  localparam logic [2:0] PAT_STROBE  = 3'd5;

  localparam logic [1:0] KIND_DRIVE = 2'd0;
  localparam logic [1:0] KIND_ECHO  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [2:0]               pattern;
    logic                     level;
    logic                     started;
    logic [31:0]              start_time;
    logic signed [DUTY_W-1:0] duty;
    logic [14:0]              period;
    logic [11:0]              step;
  } chan_entry_t;

  localparam chan_entry_t RESET_ENTRY = '{
    pattern:    PAT_INIT,
    level:      1'b0,
    started:    1'b0,
    start_time: 32'd0,
    duty:       '0,
    period:     15'(RESET_PERIOD),
    step:       12'(RESET_STEP)
  };

endpackage

// ===== rtl/lpe_if.sv =====
// ----------------------------------------------------------------------------
// lpe_in_if / lpe_out_if
// Valid/ready channels of the light pattern engine: command input and
// result output.
// ----------------------------------------------------------------------------
interface lpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  channel;
  logic [2:0]  pattern;
  logic [14:0] period;
  logic [11:0] step;

  modport source (output valid, opcode, channel, pattern, period, step, input ready);
  modport sink   (input valid, opcode, channel, pattern, period, step, output ready);
endinterface

interface lpe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  channel_out;
  logic [2:0]  pattern_out;
  logic        level;
  logic [11:0] duty;
  logic        analog_mode;
  logic [14:0] period_out;
  logic [11:0] step_out;
  logic        last;

  modport source (output valid, kind, channel_out, pattern_out, level, duty, analog_mode,
                  period_out, step_out, last, input ready);
  modport sink   (input valid, kind, channel_out, pattern_out, level, duty, analog_mode,
                  period_out, step_out, last, output ready);
endinterface

// ===== rtl/led_pattern_engine_unit.sv =====
// ----------------------------------------------------------------------------
// led_pattern_engine_unit
// Multi-channel blink / pulse / strobe / breathe pattern generator.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes commands: tick (advance the ms counter and walk all
//   channels), set pattern of all channels, set one channel, read one channel.
//   out_ch returns results: one drive result per channel on a tick (the last
//   one flagged), one echo on set-one, one reply on read; set-all returns none.
// Timing:
//   channel state sits in a CHANNELS-entry memory with a registered read port.
//   A command is taken only while the sequencer is idle. A read state fetches the
//   first entry, then the walk state handles one channel at a time (read of the next
//   entry overlaps the write-back of the current one). A tick or set-all walks all
//   channels, set-one and read a single one. Each result is registered in the
//   output register that drives out_ch.
// Reset:
//   the ms counter clears and per-entry valid bits clear, so every
//   channel reads as pattern init with period 1000 and step 1. No clearing pass.
// Stall:
//   a single output register holds the pending result; while it is full and
//   out_ch.ready is low a walk that emits results holds on its current channel.
// ----------------------------------------------------------------------------
module led_pattern_engine_unit
  import lpe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  lpe_in_if.sink   in_ch,
  lpe_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WALK
  } state_t;

  state_t       state_r;
  op_e_t        op_r;
  logic [CH_W-1:0] ch_r;
  logic [CH_W-1:0] ch_nxt;
  logic [2:0]   pat_r;
  logic [14:0]  per_r;
  logic [11:0]  stp_r;
  logic [31:0]  now_r;

  // channel state memory and its valid bits
  chan_entry_t  mem [CHANNELS];
  chan_entry_t  rdata_r;
  logic         rd_vld_r;
  logic [CHANNELS-1:0] vld_r;
  logic         rd_en;
  logic [CH_W-1:0] rd_addr;
  logic         wr_en;

  // output register
  logic         out_valid_r;
  logic [1:0]   kind_r;
  logic [3:0]   chan_out_r;
  logic [2:0]   pat_out_r;
  logic         level_r;
  logic [11:0]  duty_r;
  logic         analog_r;
  logic [14:0]  per_out_r;
  logic [11:0]  stp_out_r;
  logic         last_r;

  logic         in_acc;
  logic         chan_ok;
  op_e_t        in_op;
  chan_entry_t  cur;
  chan_entry_t  walk;
  chan_entry_t  wr_entry;
  logic [31:0]  elapsed;
  logic         due;
  logic signed [SUM_W-1:0] duty_ext;
  logic signed [SUM_W-1:0] step_ext;
  logic signed [SUM_W-1:0] duty_sum;
  logic signed [SUM_W-1:0] duty_sat;
  logic signed [SUM_W-1:0] emit_duty;
  logic [11:0]  duty_clamped;
  logic         walk_last;
  logic         emit_en;
  logic         can_go;
  logic         advance;
  logic         out_load;
  logic         analog;
  logic [1:0]   kind;

  localparam logic signed [SUM_W-1:0] DUTY_MIN  = SUM_W'(-2 * DUTY_LIMIT);
  localparam logic signed [SUM_W-1:0] DUTY_MAX  = SUM_W'(2 * DUTY_LIMIT - 1);
  localparam logic signed [SUM_W-1:0] DUTY_TOP  = SUM_W'(DUTY_LIMIT);
  localparam logic signed [SUM_W-1:0] DUTY_ZERO = SUM_W'(0);
  localparam logic signed [SUM_W-1:0] OUT_MAX   = SUM_W'(DUTY_OUT_MAX);
  localparam logic [CH_W-1:0]         LAST_CH   = CH_W'(CHANNELS - 1);

  assign in_op    = op_e_t'(in_ch.opcode);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign chan_ok  = int'(in_ch.channel) < CHANNELS;
  assign in_ch.ready = (state_r == S_IDLE);

  // entry never written since reset reads as its reset value
  assign cur = rd_vld_r ? rdata_r : RESET_ENTRY;

  assign elapsed  = now_r - cur.start_time;
  assign due      = elapsed > {17'd0, cur.period};
  assign duty_ext = SUM_W'(signed'(cur.duty));
  assign step_ext = signed'(SUM_W'(cur.step));
  assign duty_sum = cur.level ? duty_ext + step_ext : duty_ext - step_ext;

  always_comb begin
    if (duty_sum < DUTY_MIN) begin
      duty_sat = DUTY_MIN;
    end else if (duty_sum > DUTY_MAX) begin
      duty_sat = DUTY_MAX;
    end else begin
      duty_sat = duty_sum;
    end
  end

  // pattern step of one channel on a tick
  always_comb begin
    walk = cur;
    unique case (cur.pattern)
      PAT_INIT: begin
        walk         = RESET_ENTRY;
        walk.pattern = PAT_OFF;
      end
      PAT_ON: begin
        walk.level = 1'b1;
      end
      PAT_OFF: begin
        walk.level   = 1'b0;
        walk.started = 1'b0;
      end
      PAT_PULSE, PAT_STROBE: begin
        if (!cur.started) begin
          walk.started    = 1'b1;
          walk.start_time = now_r;
          walk.level      = 1'b1;
        end else if (due) begin
          if (cur.pattern == PAT_PULSE) begin
            walk.pattern = PAT_OFF;
            walk.started = 1'b0;
            walk.level   = 1'b0;
          end else begin
            walk.start_time = now_r;
            walk.level      = ~cur.level;
          end
        end
      end
      PAT_BREATHE: begin
        if (!cur.started) begin
          walk.started    = 1'b1;
          walk.start_time = now_r;
          walk.level      = 1'b0;
          walk.duty       = DUTY_W'(BREATHE_START_DUTY);
        end else if (due) begin
          walk.duty       = DUTY_W'(duty_sat);
          walk.start_time = now_r;
          if (duty_sat >= DUTY_TOP) begin
            walk.level = 1'b0;
          end
          if (duty_sat <= DUTY_ZERO) begin
            walk.level = 1'b1;
          end
        end
      end
      default: begin
        walk = cur;
      end
    endcase
  end

  // what gets written back, and what a result reports
  always_comb begin
    wr_entry = cur;
    unique case (op_r)
      OP_TICK: begin
        wr_entry = walk;
      end
      OP_SET_ALL: begin
        wr_entry.pattern = pat_r;
      end
      OP_SET_ONE: begin
        wr_entry.pattern = pat_r;
        wr_entry.period  = per_r;
        wr_entry.step    = stp_r;
      end
      OP_READ: begin
        wr_entry = cur;
      end
    endcase
  end

  always_comb begin
    unique case (op_r)
      OP_SET_ONE: kind = KIND_ECHO;
      OP_READ:    kind = KIND_READ;
      default:    kind = KIND_DRIVE;
    endcase
  end

  assign analog    = ((op_r == OP_SET_ONE) ? pat_r : cur.pattern) == PAT_BREATHE;
  assign emit_duty = SUM_W'(signed'(wr_entry.duty));

  always_comb begin
    if (emit_duty < DUTY_ZERO) begin
      duty_clamped = '0;
    end else if (emit_duty > OUT_MAX) begin
      duty_clamped = 12'(DUTY_OUT_MAX);
    end else begin
      duty_clamped = 12'(emit_duty);
    end
  end

  assign walk_last = (op_r == OP_SET_ONE) || (op_r == OP_READ) || (ch_r == LAST_CH);
  assign emit_en   = (op_r != OP_SET_ALL);
  assign can_go    = !emit_en || !out_valid_r || out_ch.ready;
  assign advance   = (state_r == S_WALK) && can_go;
  assign wr_en     = advance && (op_r != OP_READ);
  assign out_load  = advance && emit_en;
  assign ch_nxt    = ch_r + 1'b1;
  assign rd_en     = (state_r == S_READ) || (advance && !walk_last);
  assign rd_addr   = (state_r == S_READ) ? ch_r : ch_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ch_r] <= wr_entry;
    end
    if (rd_en) begin
      rdata_r  <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[ch_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      now_r       <= '0;
      op_r        <= OP_TICK;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r  <= in_op;
            pat_r <= in_ch.pattern;
            per_r <= in_ch.period;
            stp_r <= in_ch.step;
            if (in_op == OP_TICK) begin
              now_r <= now_r + 32'd1;
            end
            if (in_op == OP_TICK || in_op == OP_SET_ALL) begin
              ch_r    <= '0;
              state_r <= S_READ;
            end else if (chan_ok) begin
              ch_r    <= CH_W'(in_ch.channel);
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (advance) begin
            if (walk_last) begin
              state_r <= S_IDLE;
            end else begin
              ch_r <= ch_nxt;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
        kind_r      <= kind;
        chan_out_r  <= 4'(ch_r);
        pat_out_r   <= wr_entry.pattern;
        level_r     <= wr_entry.level;
        duty_r      <= duty_clamped;
        analog_r    <= analog;
        per_out_r   <= wr_entry.period;
        stp_out_r   <= wr_entry.step;
        last_r      <= walk_last;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.channel_out = chan_out_r;
  assign out_ch.pattern_out = pat_out_r;
  assign out_ch.level       = level_r;
  assign out_ch.duty        = duty_r;
  assign out_ch.analog_mode = analog_r;
  assign out_ch.period_out  = per_out_r;
  assign out_ch.step_out    = stp_out_r;
  assign out_ch.last        = last_r;

`ifndef ASSERT_OFF
  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten while full");

  // a tick transaction advances the ms counter by exactly one
  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == OP_TICK) |=> (now_r == $past(now_r) + 32'd1))
    else $error("ms counter did not advance on tick");

  // the flagged drive result of a walk belongs to the highest channel
  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last && out_ch.kind == KIND_DRIVE)
      |-> (out_ch.channel_out == 4'(CHANNELS - 1)))
    else $error("walk ended on wrong channel");

  // a read never writes the channel memory
  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (op_r != OP_READ))
    else $error("memory written during read");
`endif

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for led_pattern_engine_unit. Commands are driven in
// random bursts while the result side stalls on a pattern of its own. Every
// accepted command is run through a cycle-free channel model, and every
// result is checked field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lpe_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int END_CYCLES   = 40;
  localparam int RANDOM_ITEMS = 100;

  typedef struct {
    op_e_t       op;
    logic [3:0]  channel;
    logic [2:0]  pattern;
    logic [14:0] period;
    logic [11:0] step;
  } cmd_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  channel;
    logic [2:0]  pattern;
    logic        level;
    logic [11:0] duty;
    logic        analog;
    logic [14:0] period;
    logic [11:0] step;
    logic        last;
  } chan_report_t;

  logic clk;
  logic rst_n;

  lpe_in_if  in_ch ();
  lpe_out_if out_ch ();

  led_pattern_engine_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // channel model
  logic [31:0] ms_count;
  logic [2:0]  ch_pattern [CHANNELS];
  logic        ch_level   [CHANNELS];
  logic        ch_running [CHANNELS];
  logic [31:0] ch_t0      [CHANNELS];
  int          ch_duty    [CHANNELS];
  logic [14:0] ch_period  [CHANNELS];
  logic [11:0] ch_step    [CHANNELS];

  cmd_t         pending_cmds [$];
  chan_report_t expected_reports [$];

  int taken_cnt   = 0;
  int sent_cnt    = 0;
  int errors      = 0;
  int idle_cycles = 0;
  int burst_left  = 1;
  int gap_left    = 0;
  int rx_mode     = 0;
  int mode_left   = 0;
  int stall_left  = 0;

  function automatic void clear_channel(int i);
    ch_pattern[i] = PAT_OFF;
    ch_level[i]   = 1'b0;
    ch_running[i] = 1'b0;
    ch_t0[i]      = '0;
    ch_duty[i]    = 0;
    ch_period[i]  = 15'(RESET_PERIOD);
    ch_step[i]    = 12'(RESET_STEP);
  endfunction

  function automatic void report_channel(logic [1:0] kind, int i, logic analog, logic last);
    chan_report_t r;
    int d;
    d = ch_duty[i];
    if (d < 0) d = 0;
    if (d > DUTY_OUT_MAX) d = DUTY_OUT_MAX;
    r.kind    = kind;
    r.channel = 4'(i);
    r.pattern = ch_pattern[i];
    r.level   = ch_level[i];
    r.duty    = 12'(d);
    r.analog  = analog;
    r.period  = ch_period[i];
    r.step    = ch_step[i];
    r.last    = last;
    expected_reports.push_back(r);
  endfunction

  function automatic logic step_due(int i);
    return (ms_count - ch_t0[i]) > {17'd0, ch_period[i]};
  endfunction

  function automatic void advance_channel(int i);
    int d;
    case (ch_pattern[i])
      PAT_INIT: clear_channel(i);
      PAT_ON:   ch_level[i] = 1'b1;
      PAT_OFF: begin
        ch_level[i]   = 1'b0;
        ch_running[i] = 1'b0;
      end
      PAT_PULSE, PAT_STROBE: begin
        if (!ch_running[i]) begin
          ch_running[i] = 1'b1;
          ch_t0[i]      = ms_count;
          ch_level[i]   = 1'b1;
        end else if (step_due(i)) begin
          if (ch_pattern[i] == PAT_PULSE) begin
            ch_pattern[i] = PAT_OFF;
            ch_running[i] = 1'b0;
            ch_level[i]   = 1'b0;
          end else begin
            ch_t0[i]    = ms_count;
            ch_level[i] = ~ch_level[i];
          end
        end
      end
      PAT_BREATHE: begin
        if (!ch_running[i]) begin
          ch_running[i] = 1'b1;
          ch_t0[i]      = ms_count;
          ch_level[i]   = 1'b0;
          ch_duty[i]    = BREATHE_START_DUTY;
        end else if (step_due(i)) begin
          d = ch_level[i] ? ch_duty[i] + int'(ch_step[i]) : ch_duty[i] - int'(ch_step[i]);
          if (d < -2 * DUTY_LIMIT) d = -2 * DUTY_LIMIT;
          if (d > 2 * DUTY_LIMIT - 1) d = 2 * DUTY_LIMIT - 1;
          ch_duty[i] = d;
          // level doubles as ramp direction
          if (d >= DUTY_LIMIT) ch_level[i] = 1'b0;
          if (d <= 0) ch_level[i] = 1'b1;
          ch_t0[i] = ms_count;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void apply_command(cmd_t c);
    logic analog;
    case (c.op)
      OP_TICK: begin
        ms_count = ms_count + 32'd1;
        for (int i = 0; i < CHANNELS; i++) begin
          analog = (ch_pattern[i] == PAT_BREATHE);
          advance_channel(i);
          report_channel(KIND_DRIVE, i, analog, i == CHANNELS - 1);
        end
      end
      OP_SET_ALL: begin
        for (int i = 0; i < CHANNELS; i++) ch_pattern[i] = c.pattern;
      end
      OP_SET_ONE: begin
        if (c.channel < CHANNELS) begin
          ch_pattern[c.channel] = c.pattern;
          ch_period[c.channel]  = c.period;
          ch_step[c.channel]    = c.step;
          report_channel(KIND_ECHO, c.channel, c.pattern == PAT_BREATHE, 1'b1);
        end
      end
      default: begin
        if (c.channel < CHANNELS)
          report_channel(KIND_READ, c.channel, ch_pattern[c.channel] == PAT_BREATHE, 1'b1);
      end
    endcase
  endfunction

  function automatic cmd_t make_cmd(op_e_t op, int ch, int pat, int per, int stp);
    cmd_t c;
    c.op      = op;
    c.channel = 4'(ch);
    c.pattern = 3'(pat);
    c.period  = 15'(per);
    c.step    = 12'(stp);
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    int    sel;
    int    pat;
    int    per;
    int    stp;
    op_e_t op;
    sel = $urandom_range(0, 99);
    pat = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
    // short periods so pulse, strobe and breathe actually step
    per = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 3);
    stp = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 4095) : $urandom_range(0, 300);
    if (sel < 45)      op = OP_TICK;
    else if (sel < 50) op = OP_SET_ALL;
    else if (sel < 85) op = OP_SET_ONE;
    else               op = OP_READ;
    return make_cmd(op, $urandom_range(0, 15), pat, per, stp);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // command driver: bursts with random gaps
  always @(negedge clk) begin
    cmd_t c;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.opcode  <= OP_TICK;
      in_ch.channel <= '0;
      in_ch.pattern <= '0;
      in_ch.period  <= '0;
      in_ch.step    <= '0;
    end else if (sent_cnt == taken_cnt) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= c.op;
        in_ch.channel <= c.channel;
        in_ch.pattern <= c.pattern;
        in_ch.period  <= c.period;
        in_ch.step    <= c.step;
        sent_cnt++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side backpressure: free running, random, or long stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 2) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  // transaction monitor, prediction and scoreboard
  always @(posedge clk) begin
    cmd_t         c;
    chan_report_t exp_r;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        c.op      = op_e_t'(in_ch.opcode);
        c.channel = in_ch.channel;
        c.pattern = in_ch.pattern;
        c.period  = in_ch.period;
        c.step    = in_ch.step;
        apply_command(c);
        taken_cnt++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result: kind %0d channel %0d", out_ch.kind, out_ch.channel_out);
          errors++;
        end else begin
          exp_r = expected_reports.pop_front();
          check_field("kind",        exp_r.kind,    out_ch.kind);
          check_field("channel_out", exp_r.channel, out_ch.channel_out);
          check_field("pattern_out", exp_r.pattern, out_ch.pattern_out);
          check_field("level",       exp_r.level,   out_ch.level);
          check_field("duty",        exp_r.duty,    out_ch.duty);
          check_field("analog_mode", exp_r.analog,  out_ch.analog_mode);
          check_field("period_out",  exp_r.period,  out_ch.period_out);
          check_field("step_out",    exp_r.step,    out_ch.step_out);
          check_field("last",        exp_r.last,    out_ch.last);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("led_pattern_engine_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int n_items;
    rst_n = 1'b0;

    ms_count = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      clear_channel(i);
      ch_pattern[i] = PAT_INIT;
    end

    // directed: init on first tick, every pattern, field extremes
    pending_cmds.push_back(make_cmd(OP_TICK,    0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_READ,    0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SET_ONE, 0, PAT_ON, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SET_ONE, 15, PAT_PULSE, 2, 4095));
    pending_cmds.push_back(make_cmd(OP_SET_ONE, 5, PAT_BREATHE, 0, 4095));
    pending_cmds.push_back(make_cmd(OP_SET_ONE, 6, PAT_BREATHE, 32767, 1));
    pending_cmds.push_back(make_cmd(OP_SET_ONE, 7, PAT_STROBE, 0, 'hAAA));
    // undefined patterns are stored and left alone by the walk
    pending_cmds.push_back(make_cmd(OP_SET_ONE, 8, 6, 'h5555, 'h555));
    pending_cmds.push_back(make_cmd(OP_SET_ONE, 9, 7, 'h2AAA, 'hFFF));
    pending_cmds.push_back(make_cmd(OP_SET_ONE, 10, PAT_INIT, 5, 9));
    pending_cmds.push_back(make_cmd(OP_SET_ONE, 11, PAT_OFF, 1, 1));
    repeat (5) pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_READ,    15, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_READ,    5, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_READ,    8, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SET_ALL, 0, PAT_STROBE, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TICK,    0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TICK,    0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SET_ALL, 0, PAT_INIT, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TICK,    0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SET_ALL, 0, PAT_BREATHE, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TICK,    0, 0, 0, 0));

    repeat (RANDOM_ITEMS) pending_cmds.push_back(random_cmd());
    n_items = pending_cmds.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (taken_cnt < n_items || expected_reports.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("led_pattern_engine_unit test passed");
    end else begin
      $display("led_pattern_engine_unit test failed");
    end
    $finish;
  end

endmodule
